### sv/fld_pkg.sv
// ----------------------------------------------------------------------------
// fld_pkg: shared types and constants of the flash light decay envelope
// Holds the queued work record, the command and register codes, the
// default values and the Q16 saturation and color clamp helpers.
// ----------------------------------------------------------------------------
package fld_pkg;

  // Command codes on the input channel.
  localparam logic CMD_FIRE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_ENABLE     = 3'd0,
    CFG_LIGHT_LIFE = 3'd1,
    CFG_IMAGE_LIFE = 3'd2,
    CFG_PEAK       = 3'd3,
    CFG_RADIUS     = 3'd4,
    CFG_RED        = 3'd5,
    CFG_GREEN      = 3'd6,
    CFG_BLUE       = 3'd7
  } cfg_idx_t;

  localparam logic [15:0] DEF_LIFE_MS = 16'd70;
  localparam logic [30:0] DEF_PEAK    = 31'd131072;
  localparam logic [30:0] DEF_RADIUS  = 31'd458752;
  localparam logic [7:0]  COLOR_MAX   = 8'd255;

  // Multiplier operands are the Q16 values with their low byte dropped.
  localparam int unsigned MUL_W     = 23;
  localparam int unsigned PROD_W    = 2 * MUL_W;
  localparam logic [PROD_W-1:0] SAT_LIMIT = PROD_W'(8388607);
  localparam logic [30:0] SAT_MAX   = 31'h7FFF_FFFF;
  localparam logic [16:0] FRAC_ONE  = 17'd65536;

  // Quotient bits of the fraction divide, most significant first.
  localparam logic [4:0] DIV_LAST = 5'd16;

  localparam int unsigned FLD_QUEUE_DEPTH = 2;

  // One sampled state of the light, handed from the front to the back.
  typedef struct packed {
    logic               fired;
    logic               lit;
    logic [15:0]        remaining;
    logic [15:0]        total;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]        peak;
    logic [30:0]        radius;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_SQR,
    BK_SCL,
    BK_OUT
  } bk_state_t;

  // A product above the Q16 limit saturates to the largest positive value.
  function automatic logic [30:0] fld_sat(input logic [PROD_W-1:0] p);
    return (p > SAT_LIMIT) ? SAT_MAX : p[30:0];
  endfunction

  function automatic logic [7:0] fld_clamp8(input logic [15:0] v);
    return (v > {8'd0, COLOR_MAX}) ? COLOR_MAX : v[7:0];
  endfunction

endpackage

### sv/fld_front.sv
// ----------------------------------------------------------------------------
// fld_front: input side of the flash light decay envelope
// Holds the configuration registers and the light state, applies each
// accepted word and queues a snapshot of the resulting sample.
// ----------------------------------------------------------------------------
module fld_front
  import fld_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic [15:0]        in_elapsed_ms,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic               q_full,
  output logic               push,
  output job_t               push_job
);

  logic        enable_r;
  logic [15:0] light_life_r, image_life_r;
  logic [30:0] peak_cfg_r, radius_cfg_r;
  logic [15:0] red_cfg_r, green_cfg_r, blue_cfg_r;

  logic               active_r, active_nxt;
  logic               hold_r, hold_nxt;
  logic [15:0]        remain_r, remain_nxt;
  logic [15:0]        total_r, total_nxt;
  logic signed [31:0] pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt, pos_z_r, pos_z_nxt;
  logic [30:0]        peak_r, peak_nxt, radius_r, radius_nxt;
  logic [7:0]         red_r, red_nxt, green_r, green_nxt, blue_r, blue_nxt;
  logic               fired;
  logic [15:0]        life;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      light_life_r <= '0;
      image_life_r <= '0;
      peak_cfg_r   <= '0;
      radius_cfg_r <= '0;
      red_cfg_r    <= '0;
      green_cfg_r  <= '0;
      blue_cfg_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ENABLE:     enable_r     <= cfg_data[0];
        CFG_LIGHT_LIFE: light_life_r <= cfg_data[15:0];
        CFG_IMAGE_LIFE: image_life_r <= cfg_data[15:0];
        CFG_PEAK:       peak_cfg_r   <= cfg_data;
        CFG_RADIUS:     radius_cfg_r <= cfg_data;
        CFG_RED:        red_cfg_r    <= cfg_data[15:0];
        CFG_GREEN:      green_cfg_r  <= cfg_data[15:0];
        CFG_BLUE:       blue_cfg_r   <= cfg_data[15:0];
        default:        enable_r     <= enable_r;
      endcase
    end
  end

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  assign life = (light_life_r != 16'd0) ? light_life_r :
                (image_life_r != 16'd0) ? image_life_r : DEF_LIFE_MS;

  always_comb begin
    active_nxt = active_r;
    hold_nxt   = hold_r;
    remain_nxt = remain_r;
    total_nxt  = total_r;
    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    pos_z_nxt  = pos_z_r;
    peak_nxt   = peak_r;
    radius_nxt = radius_r;
    red_nxt    = red_r;
    green_nxt  = green_r;
    blue_nxt   = blue_r;
    fired      = 1'b0;
    if (push) begin
      if (in_cmd == CMD_FIRE) begin
        if (enable_r) begin
          active_nxt = 1'b1;
          hold_nxt   = 1'b1;
          remain_nxt = life;
          total_nxt  = life;
          pos_x_nxt  = in_pos_x;
          pos_y_nxt  = in_pos_y;
          pos_z_nxt  = in_pos_z;
          peak_nxt   = (peak_cfg_r != 31'd0) ? peak_cfg_r : DEF_PEAK;
          radius_nxt = (radius_cfg_r != 31'd0) ? radius_cfg_r : DEF_RADIUS;
          red_nxt    = fld_clamp8(red_cfg_r);
          green_nxt  = fld_clamp8(green_cfg_r);
          blue_nxt   = fld_clamp8(blue_cfg_r);
          fired      = 1'b1;
        end
      end else if (active_r) begin
        if (hold_r) begin
          hold_nxt = 1'b0;
        end else if (in_elapsed_ms >= remain_r) begin
          remain_nxt = '0;
          active_nxt = 1'b0;
        end else begin
          remain_nxt = remain_r - in_elapsed_ms;
        end
      end
    end
  end

  always_comb begin
    push_job.fired     = fired;
    push_job.lit       = active_nxt && (remain_nxt != 16'd0) && (total_nxt != 16'd0);
    push_job.remaining = remain_nxt;
    push_job.total     = total_nxt;
    push_job.pos_x     = pos_x_nxt;
    push_job.pos_y     = pos_y_nxt;
    push_job.pos_z     = pos_z_nxt;
    push_job.peak      = peak_nxt;
    push_job.radius    = radius_nxt;
    push_job.red       = red_nxt;
    push_job.green     = green_nxt;
    push_job.blue      = blue_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      hold_r   <= 1'b0;
      remain_r <= '0;
      total_r  <= '0;
      pos_x_r  <= '0;
      pos_y_r  <= '0;
      pos_z_r  <= '0;
      peak_r   <= '0;
      radius_r <= '0;
      red_r    <= '0;
      green_r  <= '0;
      blue_r   <= '0;
    end else begin
      active_r <= active_nxt;
      hold_r   <= hold_nxt;
      remain_r <= remain_nxt;
      total_r  <= total_nxt;
      pos_x_r  <= pos_x_nxt;
      pos_y_r  <= pos_y_nxt;
      pos_z_r  <= pos_z_nxt;
      peak_r   <= peak_nxt;
      radius_r <= radius_nxt;
      red_r    <= red_nxt;
      green_r  <= green_nxt;
      blue_r   <= blue_nxt;
    end
  end

  // The divide in the back part relies on the fraction never exceeding one.
  a_lit_frac_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_job.lit |-> push_job.remaining <= push_job.total)
    else $error("queued sample has remaining life above total life");

  a_active_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (remain_r != 16'd0) && (total_r != 16'd0))
    else $error("active light with zero remaining or total life");

endmodule

### sv/fld_queue.sv
// ----------------------------------------------------------------------------
// fld_queue: short queue of sample snapshots
// Decouples the front part from the back part so each can stall alone.
// ----------------------------------------------------------------------------
module fld_queue
  import fld_pkg::*;
#(
  parameter int unsigned DEPTH = FLD_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output job_t pop_job
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue read while empty");

endmodule

### sv/fld_back.sv
// ----------------------------------------------------------------------------
// fld_back: sample evaluation of the flash light decay envelope
// Takes one snapshot at a time and, if it is lit, divides remaining by total
// life bit by bit, squares and scales the fraction on one shared multiplier,
// and holds every finished sample in the output register until it is taken.
// ----------------------------------------------------------------------------
module fld_back
  import fld_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  job_t               q_job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_fired,
  output logic               out_lit,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [30:0]        out_intensity,
  output logic [30:0]        out_radius,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue
);

  bk_state_t         state_r, state_nxt;
  job_t              job_r, job_nxt;
  logic [16:0]       part_r, part_nxt;
  logic [16:0]       quo_r, quo_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [16:0]       frac_cap;
  logic [30:0]       shaped;
  logic [16:0]       part_diff;
  logic              part_ge;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_not_empty) begin
          state_nxt = q_job.lit ? BK_DIV : BK_OUT;
        end
      end
      BK_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = BK_SQR;
        end
      end
      BK_SQR:  state_nxt = BK_SCL;
      BK_SCL:  state_nxt = BK_OUT;
      BK_OUT: begin
        if (out_ready) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign frac_cap = (quo_r > FRAC_ONE) ? FRAC_ONE : quo_r;
  assign shaped   = fld_sat(prod_r);

  // Control outputs and multiplier operand selection.
  always_comb begin
    pop       = 1'b0;
    out_valid = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      BK_IDLE: pop = q_not_empty;
      BK_DIV:  pop = 1'b0;
      BK_SQR: begin
        mul_a = MUL_W'(frac_cap[16:8]);
        mul_b = MUL_W'(frac_cap[16:8]);
      end
      BK_SCL: begin
        mul_a = job_r.peak[30:8];
        mul_b = shaped[30:8];
      end
      BK_OUT:  out_valid = 1'b1;
      default: pop = 1'b0;
    endcase
  end

  // One restoring divide step: remaining * 65536 / total.
  assign part_ge   = (part_r >= {1'b0, job_r.total});
  assign part_diff = part_r - {1'b0, job_r.total};

  always_comb begin
    job_nxt  = job_r;
    part_nxt = part_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    prod_nxt = prod_r;
    if (pop) begin
      job_nxt  = q_job;
      part_nxt = {1'b0, q_job.remaining};
      quo_nxt  = '0;
      cnt_nxt  = DIV_LAST;
    end else if (state_r == BK_DIV) begin
      part_nxt = {(part_ge ? part_diff[15:0] : part_r[15:0]), 1'b0};
      quo_nxt  = {quo_r[15:0], part_ge};
      cnt_nxt  = cnt_r - 5'd1;
    end else if ((state_r == BK_SQR) || (state_r == BK_SCL)) begin
      prod_nxt = mul_a * mul_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    part_r <= part_nxt;
    quo_r  <= quo_nxt;
    prod_r <= prod_nxt;
  end

  assign out_fired     = job_r.fired;
  assign out_lit       = job_r.lit;
  assign out_x         = job_r.lit ? job_r.pos_x : '0;
  assign out_y         = job_r.lit ? job_r.pos_y : '0;
  assign out_z         = job_r.lit ? job_r.pos_z : '0;
  assign out_intensity = job_r.lit ? fld_sat(prod_r) : '0;
  assign out_radius    = job_r.lit ? job_r.radius : '0;
  assign out_red       = job_r.lit ? job_r.red : '0;
  assign out_green     = job_r.lit ? job_r.green : '0;
  assign out_blue      = job_r.lit ? job_r.blue : '0;

  a_frac_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV) && (cnt_r == '0) |=> quo_r <= FRAC_ONE)
    else $error("life fraction above one after divide");

endmodule

### sv/flash_light_decay_envelope.sv
// ----------------------------------------------------------------------------
// flash_light_decay_envelope: one-shot flash light with squared decay
// Order: an accepted word is queued and then popped by the idle back part;
//   a lit sample goes through the divide, square and scale states before
//   out_valid, an unlit one straight from the pop to the output state.
// Throughput: the back part takes one sample at a time, through the pop
//   cycle, the 17-step fraction divide, two passes through the shared
//   multiplier and the output state, held there until out_ready. The input
//   side takes a word each cycle until the queue before the back part is full.
// Reset: rst_n is synchronous and active low; it clears the configuration,
//   the light state, the queue count and the back part state machine.
// ----------------------------------------------------------------------------
module flash_light_decay_envelope
  import fld_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = FLD_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic [15:0]        in_elapsed_ms,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_fired,
  output logic               out_lit,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [30:0]        out_intensity,
  output logic [30:0]        out_radius,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue
);

  // The front part owns every piece of state that the model updates per
  // word: fire and tick words change it in the cycle they are accepted, so
  // the next word can follow immediately while the queue has room. Each
  // accepted word leaves a full snapshot of the light in the queue.
  logic push;
  job_t push_job;
  logic q_full;

  // The back part only evaluates snapshots, so it never needs to look back
  // at the live state and may fall behind the front by the queue depth.
  logic q_not_empty;
  logic pop;
  job_t pop_job;

  fld_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_elapsed_ms (in_elapsed_ms),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .q_full        (q_full),
    .push          (push),
    .push_job      (push_job)
  );

  fld_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_job   (pop_job)
  );

  // The intensity is peak * (remaining/total)^2 in Q16. Both products use
  // operands with the low byte dropped and saturate at the largest
  // positive 31-bit value. A word that leaves the light dark returns zeros
  // in every field except fired.
  fld_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_job         (pop_job),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_fired     (out_fired),
    .out_lit       (out_lit),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_intensity (out_intensity),
    .out_radius    (out_radius),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

endmodule
